// File: hw/rtl/tcce_pkg.sv
`timescale 1ns / 1ps
// Package for the text console cursor engine.
// Holds character codes, cell geometry, action codes and the shared structs.
// No dependencies.
package tcce_pkg;

    // Cell geometry in pixels.
    localparam int CELL_WIDTH  = 8;
    localparam int CELL_HEIGHT = 16;

    // Field widths.
    localparam int CODE_W   = 8;
    localparam int DIM_W    = 13;
    localparam int POS_W    = 12;
    localparam int ACTION_W = 2;
    // Working width for cursor arithmetic: room for a cursor near the top of
    // its range plus two cell steps.
    localparam int CALC_W   = DIM_W + 2;

    // Control characters.
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CODE_W-1:0] CODE_RETURN    = 8'd13;

    // Cell actions.
    localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DRAW  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ERASE = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_PRESENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT   = 2'd2;

    // Screen geometry as seen by the cursor logic.
    typedef struct packed {
        logic             present;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } geom_t;

    // One command for the drawing side.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    cell_x;
        logic [POS_W-1:0]    cell_y;
        logic [CODE_W-1:0]   glyph;
        logic                clear;
    } cell_cmd_t;

endpackage

// File: hw/rtl/text_console_cursor_engine_top.sv
`timescale 1ns / 1ps
// Top level of the text console cursor engine: input register, cursor
// registers, configuration registers and result register.
// Depends on tcce_pkg and tcce_cursor_step.

// The engine takes one character code per transfer and returns one cell
// command per character, one character per clock cycle when the output side
// keeps taking results. A character is registered on input. The cursor logic
// then works on it combinationally; when the result register is free or
// emptying, the command is loaded into the result register and the cursor
// registers update together. The only loop is the cursor update itself.
// Configuration writes are always accepted and should be issued only
// while no character is in flight.
module text_console_cursor_engine_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Character input.
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tcce_pkg::CODE_W-1:0]       char_code,
    // Cell command output.
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tcce_pkg::ACTION_W-1:0]     cell_action,
    output logic [tcce_pkg::POS_W-1:0]        cell_x,
    output logic [tcce_pkg::POS_W-1:0]        cell_y,
    output logic [tcce_pkg::CODE_W-1:0]       glyph_code,
    output logic                              screen_clear,
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcce_pkg::DIM_W-1:0]        cfg_data
);

    tcce_pkg::geom_t                 geom_reg;
    logic                            in_valid_reg;
    logic [tcce_pkg::CODE_W-1:0]     code_reg;
    logic [tcce_pkg::DIM_W-1:0]      cursor_x_reg;
    logic [tcce_pkg::DIM_W-1:0]      cursor_y_reg;
    logic [tcce_pkg::DIM_W-1:0]      cursor_x_next;
    logic [tcce_pkg::DIM_W-1:0]      cursor_y_next;
    logic                            out_valid_reg;
    tcce_pkg::cell_cmd_t             cmd_reg;
    tcce_pkg::cell_cmd_t             cmd_next;
    logic                            advance;
    logic                            in_take;

    // Configuration registers take every write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tcce_pkg::CFG_DISPLAY_PRESENT: geom_reg.present <= cfg_data[0];
                tcce_pkg::CFG_SCREEN_WIDTH:    geom_reg.width   <= cfg_data;
                tcce_pkg::CFG_SCREEN_HEIGHT:   geom_reg.height  <= cfg_data;
                default:                       geom_reg         <= geom_reg;
            endcase
        end
    end

    // The held character moves on when the result register is free or emptying.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            code_reg <= char_code;
        end
    end

    // Cursor logic between the input and result registers.
    tcce_cursor_step u_step
    (
        .geom   (geom_reg),
        .cur_x  (cursor_x_reg),
        .cur_y  (cursor_y_reg),
        .code   (code_reg),
        .next_x (cursor_x_next),
        .next_y (cursor_y_next),
        .cmd    (cmd_next)
    );

    // Cursor registers update as each character completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else if (advance)
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cell_action  = cmd_reg.action;
    assign cell_x       = cmd_reg.cell_x;
    assign cell_y       = cmd_reg.cell_y;
    assign glyph_code   = cmd_reg.glyph;
    assign screen_clear = cmd_reg.clear;

    // A pending result reflects the cursor it left behind: a clear puts it home.
    a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cmd_reg.clear) |-> (cursor_x_reg == '0 && cursor_y_reg == '0))
        else $error("screen clear without cursor at origin");

    // Erase never comes with a screen clear.
    a_erase_no_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cmd_reg.action == tcce_pkg::ACT_ERASE) |-> !cmd_reg.clear)
        else $error("erase command with screen clear");

    // Glyph code is zero unless a glyph is drawn.
    a_glyph_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cmd_reg.action != tcce_pkg::ACT_DRAW) |-> (cmd_reg.glyph == '0))
        else $error("glyph code set without a draw");

    // No action means no cell position.
    a_none_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cmd_reg.action == tcce_pkg::ACT_NONE)
            |-> (cmd_reg.cell_x == '0 && cmd_reg.cell_y == '0))
        else $error("cell position set without an action");

    // An empty input register always accepts.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input stalled while empty");

    // A stalled result keeps the cursor where it is.
    a_stall_holds_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> ($stable(cursor_x_reg) && $stable(cursor_y_reg)))
        else $error("cursor moved while the result was stalled");

endmodule

// File: hw/rtl/tcce_cursor_step.sv
`timescale 1ns / 1ps
// Cursor update for one character: next cursor position and the cell command.
// Depends on tcce_pkg.
module tcce_cursor_step
(
    input  tcce_pkg::geom_t                   geom,
    input  logic [tcce_pkg::DIM_W-1:0]        cur_x,
    input  logic [tcce_pkg::DIM_W-1:0]        cur_y,
    input  logic [tcce_pkg::CODE_W-1:0]       code,
    output logic [tcce_pkg::DIM_W-1:0]        next_x,
    output logic [tcce_pkg::DIM_W-1:0]        next_y,
    output tcce_pkg::cell_cmd_t               cmd
);

    localparam logic [tcce_pkg::CALC_W-1:0] CW = tcce_pkg::CALC_W'(tcce_pkg::CELL_WIDTH);
    localparam logic [tcce_pkg::CALC_W-1:0] CH = tcce_pkg::CALC_W'(tcce_pkg::CELL_HEIGHT);

    // Walk the backspace and print rules on widened copies of the cursor.
    always_comb
    begin
        logic [tcce_pkg::CALC_W-1:0] x;
        logic [tcce_pkg::CALC_W-1:0] y;
        logic [tcce_pkg::CALC_W-1:0] sw;
        logic [tcce_pkg::CALC_W-1:0] sh;
        logic                        ready;

        x     = tcce_pkg::CALC_W'(cur_x);
        y     = tcce_pkg::CALC_W'(cur_y);
        sw    = tcce_pkg::CALC_W'(geom.width);
        sh    = tcce_pkg::CALC_W'(geom.height);
        ready = geom.present && (geom.width != '0) && (geom.height != '0);
        cmd   = '0;

        if (ready)
        begin
            if (code == tcce_pkg::CODE_BACKSPACE)
            begin
                // Step back one cell, wrapping to the end of the line above.
                if (x >= CW)
                begin
                    x          = x - CW;
                    cmd.action = tcce_pkg::ACT_ERASE;
                    cmd.cell_x = x[tcce_pkg::POS_W-1:0];
                    cmd.cell_y = y[tcce_pkg::POS_W-1:0];
                end
                else if (y >= CH)
                begin
                    y          = y - CH;
                    x          = (sw >= CW) ? (sw - CW) : '0;
                    cmd.action = tcce_pkg::ACT_ERASE;
                    cmd.cell_x = x[tcce_pkg::POS_W-1:0];
                    cmd.cell_y = y[tcce_pkg::POS_W-1:0];
                end
            end
            else
            begin
                if (code == tcce_pkg::CODE_NEWLINE)
                begin
                    x = '0;
                    y = y + CH;
                end
                else if (code == tcce_pkg::CODE_RETURN)
                begin
                    x = '0;
                end
                else
                begin
                    // Upper half codes advance without drawing.
                    if (!code[tcce_pkg::CODE_W-1])
                    begin
                        cmd.action = tcce_pkg::ACT_DRAW;
                        cmd.cell_x = x[tcce_pkg::POS_W-1:0];
                        cmd.cell_y = y[tcce_pkg::POS_W-1:0];
                        cmd.glyph  = code;
                    end
                    x = x + CW;
                end

                // Wrap when the next cell does not fit on the line.
                if ((x + CW) > sw)
                begin
                    x = '0;
                    y = y + CH;
                end

                // Clear the screen when the next line does not fit.
                if ((y + CH) > sh)
                begin
                    cmd.clear = 1'b1;
                    x         = '0;
                    y         = '0;
                end
            end
        end

        next_x = ready ? x[tcce_pkg::DIM_W-1:0] : cur_x;
        next_y = ready ? y[tcce_pkg::DIM_W-1:0] : cur_y;
    end

endmodule

// File: tb/text_console_cursor_engine_top_test.sv
`timescale 1ns / 1ps
// Testbench for text_console_cursor_engine_top: directed and random character streams
// under several screen geometries, checked against a cursor tracker kept in the bench.
// Depends on tcce_pkg and the engine RTL.
module text_console_cursor_engine_top_test;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 4;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [tcce_pkg::CODE_W-1:0]    char_code;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [tcce_pkg::ACTION_W-1:0]  cell_action;
    logic [tcce_pkg::POS_W-1:0]     cell_x;
    logic [tcce_pkg::POS_W-1:0]     cell_y;
    logic [tcce_pkg::CODE_W-1:0]    glyph_code;
    logic                           screen_clear;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tcce_pkg::DIM_W-1:0]     cfg_data;

    // Bench copy of the engine's geometry and cursor.
    logic                           disp_on;
    logic [tcce_pkg::DIM_W-1:0]     scr_w;
    logic [tcce_pkg::DIM_W-1:0]     scr_h;
    logic [tcce_pkg::DIM_W-1:0]     cur_col;
    logic [tcce_pkg::DIM_W-1:0]     cur_row;

    tcce_pkg::cell_cmd_t  pending_cmds[$];
    int unsigned          mismatch_count = 0;
    int unsigned          cycle_count = 0;
    int unsigned          in_idle_pct = 0;
    int unsigned          out_stall_pct = 0;

    text_console_cursor_engine_top DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cell_action  (cell_action),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .glyph_code   (glyph_code),
        .screen_clear (screen_clear),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the command for one character and move the bench cursor.
    function automatic void track_char(input logic [tcce_pkg::CODE_W-1:0] code);
        int unsigned         x;
        int unsigned         y;
        tcce_pkg::cell_cmd_t cmd;
        x   = 32'(cur_col);
        y   = 32'(cur_row);
        cmd = '0;
        if (disp_on && scr_w != 0 && scr_h != 0)
        begin
            if (code == tcce_pkg::CODE_BACKSPACE)
            begin
                if (x >= tcce_pkg::CELL_WIDTH)
                begin
                    x          = x - tcce_pkg::CELL_WIDTH;
                    cmd.action = tcce_pkg::ACT_ERASE;
                end
                else if (y >= tcce_pkg::CELL_HEIGHT)
                begin
                    // Wrap to the last cell of the previous line; a screen
                    // narrower than one cell pins the column at zero.
                    y          = y - tcce_pkg::CELL_HEIGHT;
                    x          = (scr_w >= tcce_pkg::CELL_WIDTH) ?
                                 32'(scr_w) - tcce_pkg::CELL_WIDTH : 0;
                    cmd.action = tcce_pkg::ACT_ERASE;
                end
                if (cmd.action == tcce_pkg::ACT_ERASE)
                begin
                    cmd.cell_x = x[tcce_pkg::POS_W-1:0];
                    cmd.cell_y = y[tcce_pkg::POS_W-1:0];
                end
            end
            else
            begin
                if (code == tcce_pkg::CODE_NEWLINE)
                begin
                    x = 0;
                    y = y + tcce_pkg::CELL_HEIGHT;
                end
                else if (code == tcce_pkg::CODE_RETURN)
                begin
                    x = 0;
                end
                else
                begin
                    // Codes with the top bit set advance without drawing.
                    if (code < 8'd128)
                    begin
                        cmd.action = tcce_pkg::ACT_DRAW;
                        cmd.cell_x = x[tcce_pkg::POS_W-1:0];
                        cmd.cell_y = y[tcce_pkg::POS_W-1:0];
                        cmd.glyph  = code;
                    end
                    x = x + tcce_pkg::CELL_WIDTH;
                end
                if (x + tcce_pkg::CELL_WIDTH > scr_w)
                begin
                    x = 0;
                    y = y + tcce_pkg::CELL_HEIGHT;
                end
                if (y + tcce_pkg::CELL_HEIGHT > scr_h)
                begin
                    cmd.clear = 1'b1;
                    x         = 0;
                    y         = 0;
                end
            end
            cur_col = x[tcce_pkg::DIM_W-1:0];
            cur_row = y[tcce_pkg::DIM_W-1:0];
        end
        pending_cmds.push_back(cmd);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Send one character and record its expected command once the transfer happens.
    task automatic send_char(input logic [tcce_pkg::CODE_W-1:0] code);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid  <= 1'b0;
            char_code <= tcce_pkg::CODE_W'($urandom);
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_char(code);
    endtask

    // Stop sending and wait until every expected command has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [tcce_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tcce_pkg::DIM_W-1:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            tcce_pkg::CFG_DISPLAY_PRESENT: disp_on = data[0];
            tcce_pkg::CFG_SCREEN_WIDTH:    scr_w = data;
            tcce_pkg::CFG_SCREEN_HEIGHT:   scr_h = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_screen(input logic present, input int unsigned w, input int unsigned h);
        write_reg(tcce_pkg::CFG_DISPLAY_PRESENT, {{(tcce_pkg::DIM_W-1){1'b0}}, present});
        write_reg(tcce_pkg::CFG_SCREEN_WIDTH, w[tcce_pkg::DIM_W-1:0]);
        write_reg(tcce_pkg::CFG_SCREEN_HEIGHT, h[tcce_pkg::DIM_W-1:0]);
    endtask

    // After reset the display is absent, so nothing is drawn.
    task automatic test_display_absent();
        send_char(8'h41);
        send_char(tcce_pkg::CODE_BACKSPACE);
    endtask

    // A zero width or height keeps the engine silent.
    task automatic test_zero_dimension();
        set_screen(1'b1, 0, 64);
        send_char(8'h41);
        set_screen(1'b1, 64, 0);
        send_char(8'h42);
    endtask

    // Three cells by two lines: drawing, wrap, backspace across a line, clear.
    task automatic test_line_editing();
        set_screen(1'b1, 24, 32);
        send_char(tcce_pkg::CODE_BACKSPACE);
        send_char(8'h41);
        send_char(8'h80);
        send_char(8'h42);
        send_char(tcce_pkg::CODE_BACKSPACE);
        send_char(tcce_pkg::CODE_RETURN);
        send_char(tcce_pkg::CODE_NEWLINE);
        send_char(8'h43);
        send_char(8'h44);
        send_char(8'h45);
        send_char(8'hFF);
        send_char(8'h7F);
        send_char(8'h00);
        send_char(tcce_pkg::CODE_NEWLINE);
    endtask

    // Screen narrower than a cell: backspace wrap lands on column zero.
    task automatic test_narrow_screen();
        set_screen(1'b1, 4, 64);
        send_char(8'h41);
        send_char(tcce_pkg::CODE_BACKSPACE);
    endtask

    // A 4096 by 4096 screen, then shrink it under a cursor that lies outside.
    task automatic test_geometry_change();
        set_screen(1'b1, 4096, 4096);
        send_char(8'h41);
        send_char(8'h41);
        send_char(8'h41);
        write_reg(tcce_pkg::CFG_SCREEN_WIDTH, 13'd16);
        send_char(8'h5A);
        write_reg(tcce_pkg::CFG_SCREEN_HEIGHT, 13'd16);
        send_char(8'h5A);
    endtask

    function automatic int unsigned random_dim(input int unsigned lo, input int unsigned hi);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return 0;
        else if (roll < 15)
            return $urandom_range(lo - 1, 1);
        else if (roll < 65)
            return $urandom_range(hi, lo);
        else if (roll < 90)
            return $urandom_range(1024, hi + 1);
        else
            return 4096;
    endfunction

    function automatic logic [tcce_pkg::CODE_W-1:0] random_char();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return tcce_pkg::CODE_W'($urandom_range(126, 32));
        else if (roll < 60)
            return tcce_pkg::CODE_BACKSPACE;
        else if (roll < 68)
            return tcce_pkg::CODE_NEWLINE;
        else if (roll < 74)
            return tcce_pkg::CODE_RETURN;
        else if (roll < 84)
            return tcce_pkg::CODE_W'($urandom_range(255, 128));
        else
            return tcce_pkg::CODE_W'($urandom_range(255, 0));
    endfunction

    // Four idling phases, each a run of segments with a fresh random geometry.
    task automatic test_random_stream();
        int unsigned idle_in[4]  = '{0, 78, 0, 23};
        int unsigned idle_out[4] = '{0, 0, 78, 23};
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            in_idle_pct   = idle_in[ph];
            out_stall_pct = idle_out[ph];
            for (int seg = 0; seg < 7; seg++)
            begin
                set_screen($urandom_range(9) != 0, random_dim(tcce_pkg::CELL_WIDTH, 64),
                           random_dim(tcce_pkg::CELL_HEIGHT, 96));
                for (int n = 0; n < 25; n++)
                    send_char(random_char());
            end
        end
    endtask

    // Receiver stalls are decided once per cycle.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= out_stall_pct);

    // Compare each command transfer with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        tcce_pkg::cell_cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                $error("command transfer with no character waiting for one");
                mismatch_count++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                check_field("cell_action", want.action, cell_action);
                check_field("cell_x", want.cell_x, cell_x);
                check_field("cell_y", want.cell_y, cell_y);
                check_field("glyph_code", want.glyph, glyph_code);
                check_field("screen_clear", want.clear, screen_clear);
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("text_console_cursor_engine_top_test: FAIL");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_code = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        disp_on   = 1'b0;
        scr_w     = '0;
        scr_h     = '0;
        cur_col   = '0;
        cur_row   = '0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_display_absent();
        test_zero_dimension();
        test_line_editing();
        test_narrow_screen();
        test_geometry_change();
        test_random_stream();

        wait_drained();
        repeat (8)
            @(negedge clk);
        if (mismatch_count == 0 && pending_cmds.size() == 0)
            $display("text_console_cursor_engine_top_test: PASS");
        else
            $display("text_console_cursor_engine_top_test: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_cursor_step.sv
hw/rtl/text_console_cursor_engine_top.sv
tb/text_console_cursor_engine_top_test.sv
